FILE: rtl/assert_macros.svh
// Assertion helpers used by the RTL controller (mqmp_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: rtl/mqmp_pkg.sv
package mqmp_pkg;

   localparam int FUNC_W   = 2;
   localparam int JOB_W    = 20;
   localparam int PRIO_W   = 31;
   localparam int QUEUE_W  = 4;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD     = 2'd0,
      FUNC_EXTRACT = 2'd1,
      FUNC_MOVE    = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED     = 3'd0,
      ST_EXTRACTED = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_MOVED     = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR  = 3'd0,
      S_IDLE   = 3'd1,
      S_SCAN   = 3'd2,
      S_DRAIN  = 3'd3,
      S_FINISH = 3'd4
   } state_type;

   typedef struct packed {
      logic               valid;
      logic [QUEUE_W-1:0] queue;
      logic [PRIO_W-1:0]  prio;
      logic [JOB_W-1:0]   job;
   } slot_type;

   typedef struct packed {
      func_type           func;
      logic [JOB_W-1:0]   job;
      logic [PRIO_W-1:0]  prio;
      logic [QUEUE_W-1:0] src;
      logic [QUEUE_W-1:0] tgt;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [JOB_W-1:0]   served_job;
      logic [COUNT_W-1:0] queue_count;
      logic [QUEUE_W-1:0] reported_queue;
   } rsp_type;

endpackage

FILE: rtl/multi_queue_mergeable_max_priority.sv
// Several job queues kept in one shared table of JOB_SLOTS slots.
// Request channel (req_valid/req_ready) carries one word per operation:
// add a job to a queue, extract the highest-priority job of a queue, or
// move all jobs of one queue onto another. Every request gives exactly one
// response word on the rsp_valid/rsp_ready channel with a status, the
// extracted job id, and the count of the reported queue.
// Each operation scans the whole table once through a synchronous memory
// with one read and one write port, one slot per cycle. After the scan the
// controller passes through S_DRAIN and S_FINISH, the response is registered
// on leaving S_FINISH, and a new request is taken only back in S_IDLE.
// After reset the table is swept clean, one slot per cycle, through all
// JOB_SLOTS slots; req_ready stays low during that sweep.
// A finished response sits in an output register. The next request is
// accepted while it waits, but that request completes only once the
// receiver has taken the earlier response.
module multi_queue_mergeable_max_priority #(
   parameter int unsigned NUM_QUEUES = 16,
   parameter int unsigned JOB_SLOTS  = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [mqmp_pkg::FUNC_W-1:0]    req_func,
   input  logic [mqmp_pkg::JOB_W-1:0]     req_job_id,
   input  logic [mqmp_pkg::PRIO_W-1:0]    req_priority_req,
   input  logic [mqmp_pkg::QUEUE_W-1:0]   req_source_queue,
   input  logic [mqmp_pkg::QUEUE_W-1:0]   req_target_queue,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mqmp_pkg::STATUS_W-1:0]  rsp_status,
   output logic [mqmp_pkg::JOB_W-1:0]     rsp_served_job,
   output logic [mqmp_pkg::COUNT_W-1:0]   rsp_queue_count,
   output logic [mqmp_pkg::QUEUE_W-1:0]   rsp_reported_queue
);
   import mqmp_pkg::*;

   localparam int unsigned AW = $clog2(JOB_SLOTS);

   logic          idle, start, done, rsp_free;
   req_type       req;
   rsp_type       result;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   slot_type      mem_wdata, mem_rdata;

   assign req_ready = idle;
   assign start     = req_valid && idle;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      req.func = func_type'(req_func);
      req.job  = req_job_id;
      req.prio = req_priority_req;
      req.src  = req_source_queue;
      req.tgt  = req_target_queue;
   end

   mqmp_ctrl #(
      .NUM_QUEUES (NUM_QUEUES),
      .JOB_SLOTS  (JOB_SLOTS),
      .AW         (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req),
      .rsp_free  (rsp_free),
      .idle      (idle),
      .done      (done),
      .result    (result),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   mqmp_ram #(
      .DEPTH (JOB_SLOTS),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_served_job     = rsp_ff.served_job;
   assign rsp_queue_count    = rsp_ff.queue_count;
   assign rsp_reported_queue = rsp_ff.reported_queue;

endmodule

FILE: rtl/mqmp_ram.sv
module mqmp_ram #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  logic                clock,
   input  logic                we,
   input  logic [AW-1:0]       waddr,
   input  mqmp_pkg::slot_type  wdata,
   input  logic                re,
   input  logic [AW-1:0]       raddr,
   output mqmp_pkg::slot_type  rdata
);
   import mqmp_pkg::*;

   slot_type mem [DEPTH];
   slot_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/mqmp_ctrl.sv
`include "assert_macros.svh"

module mqmp_ctrl #(
   parameter int unsigned NUM_QUEUES = 16,
   parameter int unsigned JOB_SLOTS  = 64,
   parameter int unsigned AW         = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  mqmp_pkg::req_type  req,
   input  logic               rsp_free,
   output logic               idle,
   output logic               done,
   output mqmp_pkg::rsp_type  result,
   output logic               mem_we,
   output logic [AW-1:0]      mem_waddr,
   output mqmp_pkg::slot_type mem_wdata,
   output logic               mem_re,
   output logic [AW-1:0]      mem_raddr,
   input  mqmp_pkg::slot_type mem_rdata
);
   import mqmp_pkg::*;

   state_type          state_ff, state_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic               idx_last;
   logic               rd_pend_ff;
   logic [AW-1:0]      rd_idx_ff;
   req_type            req_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               hit_ff;
   logic [AW-1:0]      sel_idx_ff;
   logic [PRIO_W-1:0]  best_prio_ff;
   logic [JOB_W-1:0]   best_job_ff;

   logic src_ok, tgt_ok, move_on;
   logic src_match, tgt_match, count_hit, take, retag;

   assign idx_last = (idx_ff == AW'(JOB_SLOTS - 1));
   assign src_ok   = (32'(req_ff.src) < NUM_QUEUES);
   assign tgt_ok   = (32'(req_ff.tgt) < NUM_QUEUES);
   assign move_on  = (req_ff.src != req_ff.tgt) && src_ok && tgt_ok;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:  if (idx_last) state_in = S_IDLE;
         S_IDLE:   if (start) state_in = S_SCAN;
         S_SCAN:   if (idx_last) state_in = S_DRAIN;
         S_DRAIN:  state_in = S_FINISH;
         S_FINISH: if (rsp_free) state_in = S_IDLE;
         default:  state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (state_ff == S_CLEAR || state_ff == S_SCAN) begin
         idx_in = idx_last ? '0 : idx_ff + AW'(1);
      end
   end

   // Per-slot evaluation of the word returned by the memory.
   always_comb begin
      src_match = mem_rdata.valid && (mem_rdata.queue == req_ff.src);
      tgt_match = mem_rdata.valid && (mem_rdata.queue == req_ff.tgt);
      retag     = 1'b0;
      case (req_ff.func)
         FUNC_ADD: begin
            count_hit = src_match;
            take      = !mem_rdata.valid && !hit_ff;
         end
         FUNC_EXTRACT: begin
            count_hit = src_match;
            take      = src_match && (!hit_ff || mem_rdata.prio > best_prio_ff);
         end
         FUNC_MOVE: begin
            // The target's count after the move covers both tags.
            count_hit = tgt_match || (move_on && src_match);
            take      = 1'b0;
            retag     = move_on && src_match;
         end
         default: begin
            count_hit = src_match;
            take      = 1'b0;
         end
      endcase
   end

   // Outputs: memory access and result.
   always_comb begin
      idle      = (state_ff == S_IDLE);
      done      = (state_ff == S_FINISH) && rsp_free;
      mem_re    = (state_ff == S_SCAN);
      mem_raddr = idx_ff;
      mem_we    = 1'b0;
      mem_waddr = sel_idx_ff;
      mem_wdata = '0;

      result.status         = ST_EMPTY;
      result.served_job     = '0;
      result.queue_count    = count_ff;
      result.reported_queue = req_ff.src;

      case (req_ff.func)
         FUNC_ADD: begin
            if (hit_ff && src_ok) begin
               result.status      = ST_ADDED;
               result.queue_count = count_ff + COUNT_W'(1);
            end else begin
               result.status = ST_FULL;
            end
         end
         FUNC_EXTRACT: begin
            if (hit_ff) begin
               result.status      = ST_EXTRACTED;
               result.served_job  = best_job_ff;
               result.queue_count = count_ff - COUNT_W'(1);
            end
         end
         FUNC_MOVE: begin
            result.status         = ST_MOVED;
            result.reported_queue = req_ff.tgt;
         end
         default: begin
            result.status = ST_EMPTY;
         end
      endcase

      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = idx_ff;
      end else if (rd_pend_ff && retag) begin
         mem_we          = 1'b1;
         mem_waddr       = rd_idx_ff;
         mem_wdata       = mem_rdata;
         mem_wdata.queue = req_ff.tgt;
      end else if (done && req_ff.func == FUNC_ADD && hit_ff && src_ok) begin
         mem_we          = 1'b1;
         mem_wdata.valid = 1'b1;
         mem_wdata.queue = req_ff.src;
         mem_wdata.prio  = req_ff.prio;
         mem_wdata.job   = req_ff.job;
      end else if (done && req_ff.func == FUNC_EXTRACT && hit_ff) begin
         // An all-zero word frees the slot.
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         idx_ff     <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         rd_pend_ff <= mem_re;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= idx_ff;
      if (start) begin
         req_ff   <= req;
         count_ff <= '0;
         hit_ff   <= 1'b0;
      end else if (rd_pend_ff) begin
         count_ff <= count_ff + COUNT_W'(count_hit);
         if (take) begin
            hit_ff       <= 1'b1;
            sel_idx_ff   <= rd_idx_ff;
            best_prio_ff <= mem_rdata.prio;
            best_job_ff  <= mem_rdata.job;
         end
      end
   end

   `ASSERT_NEVER(a_no_write_idle, clock, reset, state_ff == S_IDLE && mem_we, "memory written while idle")
   `ASSERT_AT(a_no_same_entry, clock, reset, mem_re && mem_we |-> mem_waddr != mem_raddr, "read and write hit one entry")
   `ASSERT_AT(a_read_from_scan, clock, reset, rd_pend_ff |-> $past(state_ff) == S_SCAN, "read data outside a scan")
   `ASSERT_AT(a_start_scan, clock, reset, start |=> state_ff == S_SCAN && count_ff == '0 && !hit_ff, "scan did not start clean")
   `ASSERT_AT(a_done_idle, clock, reset, done |=> state_ff == S_IDLE && !rd_pend_ff, "finish did not return to idle")

endmodule

FILE: verif/testbench.sv
module testbench;
   import mqmp_pkg::*;

   localparam int NUM_QUEUES  = 16;
   localparam int JOB_SLOTS   = 64;
   localparam int STALL_LIMIT = 5000;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [JOB_W-1:0]  JOB_MAX     = '1;
   localparam logic [PRIO_W-1:0] PRIO_MAX    = '1;

   logic                clock;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [FUNC_W-1:0]   req_func         = '0;
   logic [JOB_W-1:0]    req_job_id       = '0;
   logic [PRIO_W-1:0]   req_priority_req = '0;
   logic [QUEUE_W-1:0]  req_source_queue = '0;
   logic [QUEUE_W-1:0]  req_target_queue = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [JOB_W-1:0]    rsp_served_job;
   logic [COUNT_W-1:0]  rsp_queue_count;
   logic [QUEUE_W-1:0]  rsp_reported_queue;

   // Shadow copy of the job table and the per-queue counts.
   logic                tbl_used [JOB_SLOTS] = '{default: 1'b0};
   logic [QUEUE_W-1:0]  tbl_queue [JOB_SLOTS];
   logic [PRIO_W-1:0]   tbl_prio [JOB_SLOTS];
   logic [JOB_W-1:0]    tbl_job [JOB_SLOTS];
   logic [COUNT_W-1:0]  queue_depth [NUM_QUEUES] = '{default: '0};
   int                  slots_taken = 0;

   rsp_type             due_responses[$];
   int                  error_count  = 0;
   bit                  req_idle     = 1'b0;
   bit                  rsp_idle     = 1'b0;
   int                  rsp_hold_len = 0;

   multi_queue_mergeable_max_priority #(
      .NUM_QUEUES(NUM_QUEUES),
      .JOB_SLOTS(JOB_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_job_id(req_job_id),
      .req_priority_req(req_priority_req),
      .req_source_queue(req_source_queue),
      .req_target_queue(req_target_queue),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_served_job(rsp_served_job),
      .rsp_queue_count(rsp_queue_count),
      .rsp_reported_queue(rsp_reported_queue)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Applies one operation to the shadow table and returns the word it should produce.
   function automatic rsp_type predict_job_op(input req_type r);
      rsp_type res;
      int      best;
      int      i;
      res = '0;
      res.reported_queue = r.src;
      best = -1;
      case (r.func)
         FUNC_ADD: begin
            for (i = 0; i < JOB_SLOTS; i++)
               if (!tbl_used[i] && best < 0)
                  best = i;
            if (best < 0) begin
               res.status = ST_FULL;
            end else begin
               tbl_used[best]  = 1'b1;
               tbl_queue[best] = r.src;
               tbl_prio[best]  = r.prio;
               tbl_job[best]   = r.job;
               queue_depth[r.src]++;
               slots_taken++;
               res.status = ST_ADDED;
            end
            res.queue_count = queue_depth[r.src];
         end
         FUNC_EXTRACT: begin
            // Strictly greater keeps the lowest slot among equal priorities.
            for (i = 0; i < JOB_SLOTS; i++)
               if (tbl_used[i] && tbl_queue[i] == r.src &&
                   (best < 0 || tbl_prio[i] > tbl_prio[best]))
                  best = i;
            if (best < 0) begin
               res.status = ST_EMPTY;
            end else begin
               tbl_used[best] = 1'b0;
               queue_depth[r.src]--;
               slots_taken--;
               res.status     = ST_EXTRACTED;
               res.served_job = tbl_job[best];
            end
            res.queue_count = queue_depth[r.src];
         end
         FUNC_MOVE: begin
            if (r.src != r.tgt) begin
               for (i = 0; i < JOB_SLOTS; i++)
                  if (tbl_used[i] && tbl_queue[i] == r.src)
                     tbl_queue[i] = r.tgt;
               queue_depth[r.tgt] = queue_depth[r.tgt] + queue_depth[r.src];
               queue_depth[r.src] = '0;
            end
            res.status         = ST_MOVED;
            res.queue_count    = queue_depth[r.tgt];
            res.reported_queue = r.tgt;
         end
         default: begin
            res.status      = ST_EMPTY;
            res.queue_count = queue_depth[r.src];
         end
      endcase
      return res;
   endfunction

   function automatic req_type make_req(input logic [FUNC_W-1:0] func,
                                        input logic [JOB_W-1:0] job,
                                        input logic [PRIO_W-1:0] prio,
                                        input logic [QUEUE_W-1:0] src,
                                        input logic [QUEUE_W-1:0] tgt);
      req_type r;
      r.func = func_type'(func);
      r.job  = job;
      r.prio = prio;
      r.src  = src;
      r.tgt  = tgt;
      return r;
   endfunction

   // Mostly a few busy queues, and half of the time a handful of priorities, so that
   // queues get deep and equal priorities meet often.
   function automatic req_type random_request();
      int               roll;
      logic [FUNC_W-1:0] func;
      roll = $urandom_range(0, 99);
      if (roll < 42)
         func = FUNC_ADD;
      else if (roll < 80)
         func = FUNC_EXTRACT;
      else if (roll < 97)
         func = FUNC_MOVE;
      else
         func = FUNC_UNUSED;
      return make_req(func, JOB_W'($urandom_range(0, 32'hFFFFF)),
                      ($urandom_range(0, 1) != 0) ? PRIO_W'($urandom())
                                                  : PRIO_W'($urandom_range(0, 7)),
                      ($urandom_range(0, 3) == 0) ? QUEUE_W'($urandom_range(0, 15))
                                                  : QUEUE_W'($urandom_range(0, 3)),
                      ($urandom_range(0, 3) == 0) ? QUEUE_W'($urandom_range(0, 15))
                                                  : QUEUE_W'($urandom_range(0, 3)));
   endfunction

   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 12)
         return 0;
      if (roll < 18)
         return $urandom_range(1, 4);
      return $urandom_range(12, 90);
   endfunction

   task automatic send_word(input req_type r);
      int gap;
      gap = req_idle ? idle_length() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_func         <= r.func;
      req_job_id       <= r.job;
      req_priority_req <= r.prio;
      req_source_queue <= r.src;
      req_target_queue <= r.tgt;
      do
         @(posedge clock);
      while (!req_ready);
      due_responses.push_back(predict_job_op(r));
   endtask

   task automatic test_empty_and_unused();
      send_word(make_req(FUNC_EXTRACT, JOB_MAX, PRIO_MAX, 4'd0, 4'd15));
      send_word(make_req(FUNC_EXTRACT, '0, '0, 4'd15, 4'd0));
      send_word(make_req(FUNC_UNUSED, '0, '0, 4'd0, 4'd0));
      send_word(make_req(FUNC_UNUSED, JOB_MAX, PRIO_MAX, 4'd15, 4'd15));
   endtask

   task automatic test_priority_order();
      send_word(make_req(FUNC_ADD, '0, '0, 4'd0, 4'd0));
      send_word(make_req(FUNC_ADD, JOB_MAX, PRIO_MAX, 4'd0, 4'd0));
      // Same top priority again: the earlier slot must come out first.
      send_word(make_req(FUNC_ADD, 20'h12345, PRIO_MAX, 4'd0, 4'd15));
      send_word(make_req(FUNC_ADD, 20'h55555, 31'h2AAAAAAA, 4'd15, 4'd0));
      send_word(make_req(FUNC_ADD, 20'hAAAAA, 31'h55555555, 4'd15, 4'd0));
      repeat (4) send_word(make_req(FUNC_EXTRACT, '0, '0, 4'd0, 4'd0));
      repeat (2) send_word(make_req(FUNC_EXTRACT, '0, '0, 4'd15, 4'd0));
   endtask

   task automatic test_moves();
      repeat (3) send_word(make_req(FUNC_ADD, 20'h00100, 31'd50, 4'd3, 4'd0));
      send_word(make_req(FUNC_ADD, 20'h00200, 31'd70, 4'd12, 4'd0));
      send_word(make_req(FUNC_MOVE, '0, '0, 4'd3, 4'd12));
      send_word(make_req(FUNC_MOVE, '0, '0, 4'd12, 4'd12));
      send_word(make_req(FUNC_MOVE, '0, '0, 4'd3, 4'd12));
      send_word(make_req(FUNC_MOVE, '0, '0, 4'd12, 4'd0));
      send_word(make_req(FUNC_MOVE, '0, '0, 4'd0, 4'd15));
      send_word(make_req(FUNC_EXTRACT, '0, '0, 4'd15, 4'd0));
   endtask

   // Fill every slot, overflow, gather everything in queue 0, then drain it.
   task automatic test_table_full();
      req_type r;
      int      q;
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      while (slots_taken < JOB_SLOTS) begin
         r = random_request();
         r.func = FUNC_ADD;
         send_word(r);
      end
      repeat (4) begin
         r = random_request();
         r.func = FUNC_ADD;
         send_word(r);
      end
      for (q = 1; q < NUM_QUEUES; q++)
         send_word(make_req(FUNC_MOVE, '0, '0, QUEUE_W'(q), 4'd0));
      repeat (JOB_SLOTS + 2)
         send_word(make_req(FUNC_EXTRACT, '0, '0, 4'd0, 4'd0));
   endtask

   // The receiver holds off long enough for the block to back up into its input.
   task automatic test_backpressure();
      req_idle     = 1'b0;
      rsp_hold_len = 500;
      repeat (12) send_word(random_request());
   endtask

   task automatic test_random_traffic(input int count, input bit idle_in, input bit idle_out);
      req_idle = idle_in;
      rsp_idle = idle_out;
      repeat (count) send_word(random_request());
   endtask

   initial begin : response_sink
      int gap_left;
      gap_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_len > 0) begin
            gap_left     = rsp_hold_len;
            rsp_hold_len = 0;
         end else if (gap_left == 0 && rsp_idle) begin
            gap_left = idle_length();
         end
         if (gap_left > 0) begin
            gap_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_responses.size() == 0) begin
            $display("%0t: response word with none expected, status %0d job %0h", $time,
                     rsp_status, rsp_served_job);
            error_count++;
         end else begin
            want = due_responses.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_served_job !== want.served_job) begin
               $display("%0t: served_job expected %0h actual %0h", $time, want.served_job,
                        rsp_served_job);
               error_count++;
            end
            if (rsp_queue_count !== want.queue_count) begin
               $display("%0t: queue_count expected %0d actual %0d", $time, want.queue_count,
                        rsp_queue_count);
               error_count++;
            end
            if (rsp_reported_queue !== want.reported_queue) begin
               $display("%0t: reported_queue expected %0d actual %0d", $time,
                        want.reported_queue, rsp_reported_queue);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet = 0;
      else
         quiet++;
      if (quiet >= STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, quiet);
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_and_unused();
      test_priority_order();
      test_moves();
      test_table_full();
      test_random_traffic(200, 1'b0, 1'b0);
      test_backpressure();
      test_random_traffic(500, 1'b1, 1'b1);
      test_random_traffic(130, 1'b0, 1'b1);

      @(negedge clock);
      req_valid <= 1'b0;
      while (due_responses.size() != 0)
         @(posedge clock);
      repeat (2 * JOB_SLOTS + 8) @(posedge clock);

      if (error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
